FILE: hdl/lcdseq_pkg.sv
// Shared types, codes and constants for the character LCD nibble sequencer.
`timescale 1ns / 1ps
package lcdseq_pkg;

  localparam int CMD_W   = 2;
  localparam int VALUE_W = 8;
  localparam int WORD_W  = 7;
  localparam int HOLD_W  = 16;
  localparam int DELAY_W = 15;
  localparam int REG_W   = 2;

  // input command codes
  localparam logic [CMD_W-1:0] CMD_INST = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DATA = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WAKE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_INIT = 2'd3;

  // configuration register indexes
  localparam logic [REG_W-1:0] REG_INIT_DELAY = 2'd0;
  localparam logic [REG_W-1:0] REG_INST_DELAY = 2'd1;
  localparam logic [REG_W-1:0] REG_DATA_DELAY = 2'd2;

  localparam logic [DELAY_W-1:0] INIT_DELAY_RST = 15'd1000;
  localparam logic [DELAY_W-1:0] INST_DELAY_RST = 15'd500;
  localparam logic [DELAY_W-1:0] DATA_DELAY_RST = 15'd250;

  // word kinds
  localparam logic [1:0] KIND_PWR  = 2'd0;
  localparam logic [1:0] KIND_WAKE = 2'd1;
  localparam logic [1:0] KIND_BYTE = 2'd2;

  localparam logic [WORD_W-1:0] PIN_EN      = 7'h40;
  localparam logic [WORD_W-1:0] PIN_RS      = 7'h20;
  localparam logic [WORD_W-1:0] WAKE_NIBBLE = 7'h03;

  localparam logic [HOLD_W-1:0] POWER_UP_WAIT_US = 16'd15000;
  localparam logic [HOLD_W-1:0] SECOND_WAIT_US   = 16'd4100;
  localparam logic [HOLD_W-1:0] THIRD_WAIT_US    = 16'd100;
  localparam logic [HOLD_W-1:0] GAP_US           = 16'd1;

  localparam logic [2:0] BYTE_LAST_STEP  = 3'd4;
  localparam logic [2:0] WAKE_LAST_STEP  = 3'd2;
  localparam logic [1:0] WAKE_LAST_PULSE = 2'd3;
  localparam logic [2:0] SETUP_LAST      = 3'd6;

  typedef struct packed {
    logic       load;
    logic       emit;
    logic [1:0] kind;
    logic [2:0] step;
    logic [1:0] wake_idx;
    logic [2:0] byte_idx;
    logic       full;
    logic       rs;
    logic       last;
    logic       set_init;
  } seq_cmd_t;

  function automatic logic [VALUE_W-1:0] setup_byte(input logic [2:0] idx);
    case (idx)
      3'd0:    setup_byte = 8'h28;
      3'd1:    setup_byte = 8'h06;
      3'd2:    setup_byte = 8'h08;
      3'd3:    setup_byte = 8'h0C;
      3'd4:    setup_byte = 8'h01;
      3'd5:    setup_byte = 8'h10;
      3'd6:    setup_byte = 8'h02;
      default: setup_byte = 8'h00;
    endcase
  endfunction

endpackage

FILE: hdl/lcdseq_if.sv
// Channel interfaces: command input, pin word results and configuration writes.
`timescale 1ns / 1ps
interface lcdseq_cmd_if;
  import lcdseq_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [VALUE_W-1:0] value;
  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

interface lcdseq_res_if;
  import lcdseq_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] pin_word;
  logic [HOLD_W-1:0] hold_us;
  logic              initialized;
  logic              last;
  modport source (output valid, pin_word, hold_us, initialized, last, input ready);
  modport sink   (input valid, pin_word, hold_us, initialized, last, output ready);
endinterface

interface lcdseq_cfg_if;
  import lcdseq_pkg::*;
  logic               valid;
  logic               ready;
  logic [REG_W-1:0]   index;
  logic [DELAY_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/lcdseq_ctrl.sv
// Sequencer state machine: walks the word list of one command.
`timescale 1ns / 1ps
module lcdseq_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [lcdseq_pkg::CMD_W-1:0] in_command,
  output logic                        in_ready,
  input  logic                        can_emit,
  output lcdseq_pkg::seq_cmd_t        cmd
);
  import lcdseq_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PWR  = 2'd1;
  localparam logic [1:0] ST_WAKE = 2'd2;
  localparam logic [1:0] ST_BYTE = 2'd3;

  logic [1:0] state, state_next;
  logic [2:0] step, step_next;
  logic [1:0] wake_idx, wake_idx_next;
  logic [2:0] byte_idx, byte_idx_next;
  logic       full, full_next;
  logic       rs, rs_next;

  always_comb begin
    state_next    = state;
    step_next     = step;
    wake_idx_next = wake_idx;
    byte_idx_next = byte_idx;
    full_next     = full;
    rs_next       = rs;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.step      = step;
    cmd.wake_idx  = wake_idx;
    cmd.byte_idx  = byte_idx;
    cmd.full      = full;
    cmd.rs        = rs;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load      = 1'b1;
          step_next     = '0;
          wake_idx_next = '0;
          byte_idx_next = '0;
          full_next     = (in_command == CMD_INIT);
          rs_next       = (in_command == CMD_DATA);
          case (in_command)
            CMD_INST: state_next = ST_BYTE;
            CMD_DATA: state_next = ST_BYTE;
            CMD_WAKE: state_next = ST_WAKE;
            default:  state_next = ST_PWR;
          endcase
        end
      end
      ST_PWR: begin
        cmd.kind = KIND_PWR;
        if (can_emit) begin
          cmd.emit   = 1'b1;
          state_next = ST_WAKE;
        end
      end
      ST_WAKE: begin
        cmd.kind = KIND_WAKE;
        cmd.last = (step == WAKE_LAST_STEP) && !full;
        if (can_emit) begin
          cmd.emit  = 1'b1;
          step_next = step + 3'd1;
          if (step == WAKE_LAST_STEP) begin
            step_next = '0;
            if (!full) begin
              state_next = ST_IDLE;
            end else if (wake_idx == WAKE_LAST_PULSE) begin
              state_next = ST_BYTE;
            end else begin
              wake_idx_next = wake_idx + 2'd1;
            end
          end
        end
      end
      ST_BYTE: begin
        cmd.kind     = KIND_BYTE;
        cmd.last     = (step == BYTE_LAST_STEP) && (!full || byte_idx == SETUP_LAST);
        cmd.set_init = (step == BYTE_LAST_STEP) && full && (byte_idx == SETUP_LAST);
        if (can_emit) begin
          cmd.emit  = 1'b1;
          step_next = step + 3'd1;
          if (step == BYTE_LAST_STEP) begin
            step_next = '0;
            if (cmd.last) begin
              state_next = ST_IDLE;
            end else begin
              byte_idx_next = byte_idx + 3'd1;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step     <= '0;
      wake_idx <= '0;
      byte_idx <= '0;
      full     <= 1'b0;
      rs       <= 1'b0;
    end else begin
      state    <= state_next;
      step     <= step_next;
      wake_idx <= wake_idx_next;
      byte_idx <= byte_idx_next;
      full     <= full_next;
      rs       <= rs_next;
    end
  end

endmodule

FILE: hdl/lcdseq_dp.sv
// Datapath: delay registers, pin word and hold generation, result register.
`timescale 1ns / 1ps
module lcdseq_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  lcdseq_pkg::seq_cmd_t          cmd,
  output logic                          can_emit,
  input  logic [lcdseq_pkg::VALUE_W-1:0] in_value,
  input  logic                          cfg_valid,
  input  logic [lcdseq_pkg::REG_W-1:0]   cfg_index,
  input  logic [lcdseq_pkg::DELAY_W-1:0] cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lcdseq_pkg::WORD_W-1:0]  out_pin_word,
  output logic [lcdseq_pkg::HOLD_W-1:0]  out_hold_us,
  output logic                          out_initialized,
  output logic                          out_last
);
  import lcdseq_pkg::*;

  logic [DELAY_W-1:0] wake_hold, inst_settle, data_settle;
  logic [VALUE_W-1:0] value;
  logic               init_done;

  logic [VALUE_W-1:0] byte_sel;
  logic [3:0]         nibble;
  logic [HOLD_W-1:0]  wake_extra;
  logic [WORD_W-1:0]  word;
  logic [HOLD_W-1:0]  hold;

  assign can_emit = !out_valid || out_ready;

  always_comb begin
    byte_sel   = cmd.full ? setup_byte(cmd.byte_idx) : value;
    nibble     = (cmd.step < 3'd3) ? byte_sel[7:4] : byte_sel[3:0];
    wake_extra = '0;
    if (cmd.full && cmd.wake_idx == 2'd0) begin
      wake_extra = SECOND_WAIT_US;
    end else if (cmd.full && cmd.wake_idx == 2'd1) begin
      wake_extra = THIRD_WAIT_US;
    end
    word = '0;
    hold = GAP_US;
    case (cmd.kind)
      KIND_PWR: begin
        hold = POWER_UP_WAIT_US;
      end
      KIND_WAKE: begin
        word = WAKE_NIBBLE | ((cmd.step == 3'd1) ? PIN_EN : '0);
        if (cmd.step == WAKE_LAST_STEP) begin
          hold = {1'b0, wake_hold} + wake_extra;
        end
      end
      KIND_BYTE: begin
        word = {3'b000, nibble} | (cmd.rs ? PIN_RS : '0)
             | ((cmd.step == 3'd1 || cmd.step == 3'd3) ? PIN_EN : '0);
        if (cmd.step == BYTE_LAST_STEP) begin
          hold = {1'b0, cmd.rs ? data_settle : inst_settle};
        end
      end
      default: begin
        word = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wake_hold   <= INIT_DELAY_RST;
      inst_settle <= INST_DELAY_RST;
      data_settle <= DATA_DELAY_RST;
      init_done   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_INIT_DELAY: wake_hold   <= cfg_data;
          REG_INST_DELAY: inst_settle <= cfg_data;
          REG_DATA_DELAY: data_settle <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.emit && cmd.set_init) begin
        init_done <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value <= in_value;
    end
    if (cmd.emit) begin
      out_pin_word    <= word;
      out_hold_us     <= hold;
      out_initialized <= init_done | cmd.set_init;
      out_last        <= cmd.last;
    end
  end

endmodule

FILE: hdl/char_lcd_nibble_sequencer_core.sv
// Top level of the 4-bit character LCD nibble sequencer.
`timescale 1ns / 1ps
// Usage:
//   cmd : one transaction per command (instruction byte, data byte, wake-up
//         pulse, full power-on init) plus the byte to send.
//   res : one transaction per LCD pin word with its hold time in microseconds,
//         the initialized flag and a last marker on the final word of a command.
//   cfg : register writes (init, instruction and data settle delays), always
//         ready; write only while the sequencer is idle.
// Timing: a command is taken while the controller is idle, then the controller emits
//   one word per cycle into the result register while that register can take one: 5 words
//   for a byte, 3 for a wake-up pulse, 48 for a full init. The next command is taken
//   once the last word has entered the result register.
//   The first word enters the result register after the controller has left idle.
// Stalls: while res.ready is low a pending word holds in the result register and the word
//   sequence pauses; nothing is dropped.
// Reset: delays return to 1000/500/250 us, initialized clears, no result pending.
module char_lcd_nibble_sequencer_core (
  input logic          clk,
  input logic          rst,
  lcdseq_cmd_if.sink   cmd,
  lcdseq_res_if.source res,
  lcdseq_cfg_if.sink   cfg
);
  import lcdseq_pkg::*;

  seq_cmd_t seq_cmd;
  logic     can_emit;

  assign cfg.ready = 1'b1;

  lcdseq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (cmd.valid),
    .in_command (cmd.command),
    .in_ready   (cmd.ready),
    .can_emit   (can_emit),
    .cmd        (seq_cmd)
  );

  lcdseq_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (seq_cmd),
    .can_emit        (can_emit),
    .in_value        (cmd.value),
    .cfg_valid       (cfg.valid),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .out_valid       (res.valid),
    .out_ready       (res.ready),
    .out_pin_word    (res.pin_word),
    .out_hold_us     (res.hold_us),
    .out_initialized (res.initialized),
    .out_last        (res.last)
  );

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the 4-bit character LCD nibble sequencer core.
`timescale 1ns / 1ps
module tb_top;
  import lcdseq_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int NUM_DIRECTED = 14;
  localparam int PHASE_ITEMS  = 99;

  // spare register index, the block ignores writes to it
  localparam logic [REG_W-1:0] REG_UNUSED = 2'd3;

  localparam logic [VALUE_W-1:0] SETUP_SEQ [7] = '{8'h28, 8'h06, 8'h08, 8'h0C, 8'h01, 8'h10,
                                                   8'h02};

  typedef struct packed {
    logic [WORD_W-1:0] pin_word;
    logic [HOLD_W-1:0] hold_us;
    logic              initialized;
    logic              last;
  } pin_beat_t;

  typedef struct packed {
    logic [CMD_W-1:0]       command;
    logic [VALUE_W-1:0]     value;
    logic                   typed;
    logic [0:4][WORD_W-1:0] words;
    logic [HOLD_W-1:0]      settle;
    logic                   initialized;
  } stim_row_t;

  typedef enum logic [1:0] {SINK_FREE, SINK_COIN, SINK_PERIODIC, SINK_SLOW} sink_mode_e;

  // typed rows hold the words of a byte or wake-up pulse; the last word holds for settle
  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    '{CMD_INST, 8'h00, 1'b1, '{7'h00, 7'h40, 7'h00, 7'h40, 7'h00}, 16'd500, 1'b0},
    '{CMD_INST, 8'hFF, 1'b1, '{7'h0F, 7'h4F, 7'h0F, 7'h4F, 7'h0F}, 16'd500, 1'b0},
    '{CMD_DATA, 8'h00, 1'b1, '{7'h20, 7'h60, 7'h20, 7'h60, 7'h20}, 16'd250, 1'b0},
    '{CMD_DATA, 8'hFF, 1'b1, '{7'h2F, 7'h6F, 7'h2F, 7'h6F, 7'h2F}, 16'd250, 1'b0},
    '{CMD_WAKE, 8'hA5, 1'b1, '{7'h03, 7'h43, 7'h03, 7'h00, 7'h00}, 16'd1000, 1'b0},
    '{CMD_INST, 8'hA5, 1'b0, '0, '0, 1'b0},
    '{CMD_DATA, 8'h5A, 1'b0, '0, '0, 1'b0},
    '{CMD_INIT, 8'h00, 1'b0, '0, '0, 1'b0},
    '{CMD_INST, 8'h3C, 1'b1, '{7'h03, 7'h43, 7'h03, 7'h4C, 7'h0C}, 16'd500, 1'b1},
    '{CMD_DATA, 8'hC3, 1'b0, '0, '0, 1'b0},
    '{CMD_WAKE, 8'hFF, 1'b0, '0, '0, 1'b0},
    '{CMD_INIT, 8'hFF, 1'b0, '0, '0, 1'b0},
    '{CMD_DATA, 8'h81, 1'b0, '0, '0, 1'b0},
    '{CMD_INST, 8'h7E, 1'b0, '0, '0, 1'b0}
  };

  logic clk;
  logic rst;

  lcdseq_cmd_if cmd_ch ();
  lcdseq_res_if res_ch ();
  lcdseq_cfg_if cfg_ch ();

  char_lcd_nibble_sequencer_core dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch.sink),
    .res (res_ch.source),
    .cfg (cfg_ch.sink)
  );

  // predictor state
  logic [DELAY_W-1:0] wake_hold_us;
  logic [DELAY_W-1:0] inst_settle_us;
  logic [DELAY_W-1:0] data_settle_us;
  logic               lcd_ready;

  pin_beat_t expected_words [$];
  pin_beat_t seq_words [$];

  int cycles;
  int mismatches;
  int words_checked;
  int items_sent;
  int inits_sent;
  int reg_writes;
  int burst_left;

  sink_mode_e sink_mode;
  int         sink_left;
  int         sink_tick;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles,
               expected_words.size());
      $display("status: fail");
      $finish;
    end
  end

  function automatic void report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at cycle %0d: %s", cycles, msg);
  endfunction

  function automatic void stage_word(logic [WORD_W-1:0] w, logic [HOLD_W-1:0] h);
    pin_beat_t b;
    b.pin_word    = w;
    b.hold_us     = h;
    b.initialized = lcd_ready;
    b.last        = 1'b0;
    seq_words.push_back(b);
  endfunction

  // high nibble first, enable strobed once per nibble
  function automatic void stage_byte(logic [VALUE_W-1:0] byt, logic rs_bit,
                                     logic [HOLD_W-1:0] settle);
    logic [WORD_W-1:0] rs;
    logic [WORD_W-1:0] hi;
    logic [WORD_W-1:0] lo;
    rs = rs_bit ? PIN_RS : '0;
    hi = {3'b000, byt[7:4]};
    lo = {3'b000, byt[3:0]};
    stage_word(rs | hi, GAP_US);
    stage_word(PIN_EN | rs | hi, GAP_US);
    stage_word(rs | hi, GAP_US);
    stage_word(PIN_EN | rs | lo, GAP_US);
    stage_word(rs | lo, settle);
  endfunction

  function automatic void stage_wake(logic [HOLD_W-1:0] extra);
    stage_word(WAKE_NIBBLE, GAP_US);
    stage_word(PIN_EN | WAKE_NIBBLE, GAP_US);
    stage_word(WAKE_NIBBLE, {1'b0, wake_hold_us} + extra);
  endfunction

  function automatic void predict_words(logic [CMD_W-1:0] c, logic [VALUE_W-1:0] v);
    pin_beat_t b;
    seq_words.delete();
    case (c)
      CMD_INST: stage_byte(v, 1'b0, {1'b0, inst_settle_us});
      CMD_DATA: stage_byte(v, 1'b1, {1'b0, data_settle_us});
      CMD_WAKE: stage_wake('0);
      CMD_INIT: begin
        stage_word('0, POWER_UP_WAIT_US);
        stage_wake(SECOND_WAIT_US);
        stage_wake(THIRD_WAIT_US);
        stage_wake('0);
        stage_wake('0);
        foreach (SETUP_SEQ[i]) stage_byte(SETUP_SEQ[i], 1'b0, {1'b0, inst_settle_us});
        lcd_ready = 1'b1;
      end
      default: ;
    endcase
    foreach (seq_words[i]) begin
      b = seq_words[i];
      if (i == seq_words.size() - 1) begin
        b.last = 1'b1;
        // flag flips on the final word of an init
        if (c == CMD_INIT) b.initialized = 1'b1;
      end
      expected_words.push_back(b);
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    pin_beat_t want;
    pin_beat_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      words_checked++;
      got = '{res_ch.pin_word, res_ch.hold_us, res_ch.initialized, res_ch.last};
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h hold %0d init %b last %b",
                                  got.pin_word, got.hold_us, got.initialized, got.last));
      end else begin
        want = expected_words.pop_front();
        if (got !== want)
          report_mismatch($sformatf(
            "word %h/%h hold %0d/%0d init %b/%b last %b/%b (expected/actual)",
            want.pin_word, got.pin_word, want.hold_us, got.hold_us,
            want.initialized, got.initialized, want.last, got.last));
      end
    end
  end

  // receiver back-pressure, switching between stall patterns
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      sink_mode    <= SINK_FREE;
      sink_left    <= 0;
      sink_tick    <= 0;
    end else begin
      if (sink_left == 0) begin
        sink_mode <= sink_mode_e'($urandom_range(3, 0));
        sink_left <= $urandom_range(300, 20);
      end else begin
        sink_left <= sink_left - 1;
      end
      sink_tick <= sink_tick + 1;
      case (sink_mode)
        SINK_FREE:     res_ch.ready <= 1'b1;
        SINK_COIN:     res_ch.ready <= ($urandom_range(1, 0) == 1);
        SINK_PERIODIC: res_ch.ready <= (sink_tick % 7) < 4;
        SINK_SLOW:     res_ch.ready <= ($urandom_range(3, 0) == 0);
        default:       res_ch.ready <= 1'b1;
      endcase
    end
  end

  task automatic push_cmd(input logic [CMD_W-1:0] c, input logic [VALUE_W-1:0] v);
    cmd_ch.valid   <= 1'b1;
    cmd_ch.command <= c;
    cmd_ch.value   <= v;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    items_sent++;
    if (c == CMD_INIT) inits_sent++;
  endtask

  // bursts of commands with random gaps, now and then a long gap-free stretch
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(6, 0);
      if (gap > 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 20) : $urandom_range(6, 1);
    end
  endtask

  task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [VALUE_W-1:0] v);
    push_cmd(c, v);
    predict_words(c, v);
    pace_sender();
  endtask

  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_W-1:0] idx, input logic [DELAY_W-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_INIT_DELAY: wake_hold_us   = d;
      REG_INST_DELAY: inst_settle_us = d;
      REG_DATA_DELAY: data_settle_us = d;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic load_delays(input logic [DELAY_W-1:0] wake_d, input logic [DELAY_W-1:0] inst_d,
                             input logic [DELAY_W-1:0] data_d);
    write_reg(REG_INIT_DELAY, wake_d);
    write_reg(REG_INST_DELAY, inst_d);
    write_reg(REG_DATA_DELAY, data_d);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(input int count, input bit pause_midway);
    int r;
    logic [CMD_W-1:0] c;
    for (int k = 0; k < count; k++) begin
      if (pause_midway && k == count / 2) drain();
      r = $urandom_range(99, 0);
      if (r < 35)      c = CMD_INST;
      else if (r < 75) c = CMD_DATA;
      else if (r < 90) c = CMD_WAKE;
      else             c = CMD_INIT;
      send_cmd(c, VALUE_W'($urandom_range(255, 0)));
    end
    drain();
  endtask

  initial begin
    stim_row_t row;
    pin_beat_t b;
    int n;
    rst            <= 1'b1;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.command <= CMD_INST;
    cmd_ch.value   <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= REG_INIT_DELAY;
    cfg_ch.data    <= '0;
    mismatches     = 0;
    words_checked  = 0;
    items_sent     = 0;
    inits_sent     = 0;
    reg_writes     = 0;
    burst_left     = 0;
    wake_hold_us   = INIT_DELAY_RST;
    inst_settle_us = INST_DELAY_RST;
    data_settle_us = DATA_DELAY_RST;
    lcd_ready      = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at reset delays
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      row = DIRECTED[i];
      push_cmd(row.command, row.value);
      if (row.typed) begin
        n = (row.command == CMD_WAKE) ? 3 : 5;
        for (int j = 0; j < n; j++) begin
          b.pin_word    = row.words[j];
          b.hold_us     = (j == n - 1) ? row.settle : GAP_US;
          b.initialized = row.initialized;
          b.last        = (j == n - 1);
          expected_words.push_back(b);
        end
      end else begin
        predict_words(row.command, row.value);
      end
      pace_sender();
    end
    drain();

    // widest delays, plus a write to the unused index
    load_delays(15'h7FFF, 15'h7FFF, 15'h7FFF);
    write_reg(REG_UNUSED, 15'h7FFF);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    random_phase(PHASE_ITEMS, 1'b1);

    load_delays(15'd1, 15'd1, 15'd1);
    random_phase(PHASE_ITEMS, 1'b0);

    load_delays(DELAY_W'($urandom_range(32767, 1)), DELAY_W'($urandom_range(32767, 1)),
                DELAY_W'($urandom_range(32767, 1)));
    random_phase(PHASE_ITEMS, 1'b0);

    // zero data settle and wake holds; wake holds keep only the fixed extras
    load_delays(15'd0, DELAY_W'($urandom_range(32767, 1)), 15'd0);
    random_phase(PHASE_ITEMS, 1'b0);

    repeat (20) @(posedge clk);

    $display("sent %0d commands (%0d full inits) over 5 delay settings, %0d register writes",
             items_sent, inits_sent, reg_writes);
    $display("checked %0d pin words, %0d mismatches, %0d words never seen",
             words_checked, mismatches, expected_words.size());
    if (mismatches == 0 && expected_words.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
